[design/absr_pkg.sv]
// ----------------------------------------------------------------------------
// absr_pkg: shared types and constants of the shape rasterizer
// Frame geometry, command codes, iterative unit control and pixel helpers.
// ----------------------------------------------------------------------------
package absr_pkg;

  // frame store geometry (power-of-two sizes, pixel at y*MAX_WIDTH + x)
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XB         = $clog2(MAX_WIDTH);
  localparam int YB         = $clog2(MAX_HEIGHT);
  localparam int AW         = XB + YB;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  // working coordinate width and frame register width
  localparam int CW    = 15;
  localparam int EXT_W = 9;

  localparam logic [EXT_W-1:0] MAX_W_EXT   = EXT_W'(MAX_WIDTH);
  localparam logic [EXT_W-1:0] MAX_H_EXT   = EXT_W'(MAX_HEIGHT);
  localparam logic [16:0]      COUNT_LIMIT = 17'h10000;

  // command codes
  typedef enum logic [2:0] {
    OP_POINT = 3'd0,
    OP_RECT  = 3'd1,
    OP_CIRC  = 3'd2,
    OP_OUTL  = 3'd3,
    OP_LINE  = 3'd4,
    OP_CLEAR = 3'd5,
    OP_READ  = 3'd6
  } op_t;

  // configuration register indexes
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // shift-subtract unit modes
  typedef enum logic {
    ITER_SQRT = 1'b0,
    ITER_DIV  = 1'b1
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  typedef struct packed {
    logic done;
  } iter_sts_t;

  // sign extend a 13-bit field to the working width
  function automatic logic signed [CW-1:0] sx13(input logic [12:0] v);
    sx13 = $signed({{(CW-13){v[12]}}, v});
  endfunction

  // pixel lies inside the active frame
  function automatic logic in_frame(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y,
                                    input logic [EXT_W-1:0] ew,
                                    input logic [EXT_W-1:0] eh);
    logic signed [CW-1:0] ews;
    logic signed [CW-1:0] ehs;
    ews = $signed({{(CW-EXT_W){1'b0}}, ew});
    ehs = $signed({{(CW-EXT_W){1'b0}}, eh});
    in_frame = (x >= 0) && (x < ews) && (y >= 0) && (y < ehs);
  endfunction

  // frame store address of a pixel
  function automatic logic [AW-1:0] pix_addr(input logic signed [CW-1:0] x,
                                             input logic signed [CW-1:0] y);
    pix_addr = {y[YB-1:0], x[XB-1:0]};
  endfunction

endpackage

[design/absr_iter.sv]
// ----------------------------------------------------------------------------
// absr_iter: shared shift-subtract unit
// Integer square root (two radicand bits a step, 10 steps) or unsigned
// division (one dividend bit a step, 13 steps) on one compare and subtract.
// ----------------------------------------------------------------------------
module absr_iter (
  input  logic                clk,
  input  logic                rst,
  input  absr_pkg::iter_ctl_t ctl,
  input  logic [19:0]         arg,
  input  logic [12:0]         den,
  output absr_pkg::iter_sts_t sts,
  output logic [12:0]         res,
  output logic [12:0]         rmd
);

  localparam logic [3:0] SQRT_STEPS = 4'd10;
  localparam logic [3:0] DIV_STEPS  = 4'd13;

  logic                 active;
  logic                 done_q;
  logic [3:0]           cnt;
  absr_pkg::iter_mode_t mode_q;
  logic [12:0]          acc;
  logic [19:0]          src;
  logic [12:0]          res_q;
  logic [13:0]          cand;
  logic [13:0]          sub;
  logic [13:0]          diff;
  logic                 ge;

  // shared compare and subtract
  always_comb begin
    if (mode_q == absr_pkg::ITER_SQRT) begin
      cand = {acc[11:0], src[19:18]};
      sub  = {res_q[11:0], 2'b01};
    end else begin
      cand = {acc, src[19]};
      sub  = {1'b0, den};
    end
    ge   = (cand >= sub);
    diff = cand - sub;
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl.start) begin
        active <= 1'b1;
        cnt    <= (ctl.mode == absr_pkg::ITER_SQRT) ? SQRT_STEPS : DIV_STEPS;
      end else if (active) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          active <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_q <= ctl.mode;
      acc    <= '0;
      res_q  <= '0;
      src    <= (ctl.mode == absr_pkg::ITER_SQRT) ? arg : {arg[12:0], 7'b0};
    end else if (active) begin
      acc   <= ge ? diff[12:0] : cand[12:0];
      res_q <= {res_q[11:0], ge};
      src   <= (mode_q == absr_pkg::ITER_SQRT) ? {src[17:0], 2'b00} : {src[18:0], 1'b0};
    end
  end

  assign sts.done = done_q;
  assign res      = res_q;
  assign rmd      = acc;

endmodule

[design/absr_frame.sv]
// ----------------------------------------------------------------------------
// absr_frame: ARGB frame store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module absr_frame (
  input  logic                    clk,
  input  logic                    we,
  input  logic [absr_pkg::AW-1:0] waddr,
  input  logic [31:0]             wdata,
  input  logic [absr_pkg::AW-1:0] raddr,
  output logic [31:0]             rdata
);

  logic [31:0] mem [absr_pkg::DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/absr_blend.sv]
// ----------------------------------------------------------------------------
// absr_blend: per-channel alpha blend
// floor((a*src + (255-a)*dst)/255) on red, green and blue; alpha from source.
// ----------------------------------------------------------------------------
module absr_blend (
  input  logic [31:0] src,
  input  logic [31:0] dst,
  output logic [31:0] pix
);

  always_comb begin
    logic [7:0]  a;
    logic [16:0] v;
    logic [16:0] q;
    a   = src[31:24];
    pix = {a, 24'h0};
    for (int i = 0; i < 3; i++) begin
      v = 17'(a * src[i*8 +: 8]) + 17'((8'hFF - a) * dst[i*8 +: 8]);
      // exact divide by 255 for values below 65535
      q = (v + 17'd1 + (v >> 8)) >> 8;
      pix[i*8 +: 8] = q[7:0];
    end
  end

endmodule

[design/alpha_blend_shape_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// alpha_blend_shape_rasterizer_unit: command-driven 2D rasterizer
// Points, rectangles, filled and outlined circles, lines, clear and read over a frame of up to 256x256.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low; the result appears
// for exactly one cycle with done and cannot be held off by the receiver.
// After reset the unit is busy while it clears the frame store. Every
// command starts in setup and ends in the done state. A visited pixel goes
// through address, read-blend-write and advance steps inside the frame and
// skips read-blend-write outside it, all on the one frame store. Circles and
// outlines add a square root per column in the shared shift-subtract unit
// (10 steps); non-vertical lines add 13 division steps once, plus a rounding
// step per column. Clear writes every store entry once; read returns the
// pixel from the registered read port. Configuration writes are always ready.
module alpha_blend_shape_rasterizer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic [31:0]        color,
  input  logic signed [12:0] x0,
  input  logic signed [12:0] y0,
  input  logic signed [12:0] x1,
  input  logic signed [12:0] y1,
  input  logic [11:0]        rect_width,
  input  logic [11:0]        rect_height,
  input  logic [9:0]         radius,
  output logic               done,
  output logic [31:0]        read_pixel,
  output logic [16:0]        pixels_drawn,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int CW = absr_pkg::CW;
  localparam int AW = absr_pkg::AW;

  typedef enum logic [13:0] {
    S_INIT      = 14'b00000000000001,
    S_IDLE      = 14'b00000000000010,
    S_SETUP     = 14'b00000000000100,
    S_SQ        = 14'b00000000001000,
    S_ROOT      = 14'b00000000010000,
    S_ROOT_WAIT = 14'b00000000100000,
    S_DIV_WAIT  = 14'b00000001000000,
    S_LROUND    = 14'b00000010000000,
    S_PLOT      = 14'b00000100000000,
    S_BLEND     = 14'b00001000000000,
    S_STEP      = 14'b00010000000000,
    S_CLEAR     = 14'b00100000000000,
    S_READ      = 14'b01000000000000,
    S_DONE      = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration and command registers
  logic [8:0]          fw;
  logic [8:0]          fh;
  absr_pkg::op_t       op_q;
  logic [31:0]         col_q;
  logic [12:0]         x0_q;
  logic [12:0]         y0_q;
  logic [12:0]         x1_q;
  logic [12:0]         y1_q;
  logic [11:0]         rw_q;
  logic [11:0]         rh_q;
  logic [9:0]          r_q;

  // walk registers
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] base_x;
  logic signed [CW-1:0] lim_x;
  logic signed [CW-1:0] lim_y;
  logic signed [10:0]   dx;
  logic signed [CW-1:0] yoff;
  logic [9:0]           h_q;
  logic                 pass;
  logic                 vert;
  logic [19:0]          rr;
  logic [19:0]          dd;
  logic [12:0]          den_q;
  logic                 dyneg;
  logic signed [CW-1:0] dq;
  logic [12:0]          dr;
  logic signed [CW-1:0] lq;
  logic [12:0]          lrem;
  logic [AW-1:0]        sweep;
  logic [16:0]          cnt;
  logic [31:0]          rd;

  // combinational helpers
  logic [8:0]           eff_w;
  logic [8:0]           eff_h;
  logic signed [CW-1:0] ews;
  logic signed [CW-1:0] ehs;
  logic signed [CW-1:0] x0s;
  logic signed [CW-1:0] y0s;
  logic signed [CW-1:0] x1s;
  logic signed [CW-1:0] y1s;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] xe_raw;
  logic signed [CW-1:0] ye_raw;
  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  logic                 lswap;
  logic signed [CW-1:0] xa;
  logic signed [CW-1:0] ya;
  logic signed [CW-1:0] xb;
  logic signed [CW-1:0] dy_line;
  logic signed [CW-1:0] dy_mag;
  logic [12:0]          dy_abs;
  logic signed [CW-1:0] den_line;
  logic signed [10:0]   dx_neg;
  logic [9:0]           dx_abs;
  logic signed [CW-1:0] dx_ext;
  logic signed [CW-1:0] h_ext;
  logic signed [10:0]   r_s;
  logic [9:0]           mul_a;
  logic [9:0]           mul_b;
  logic [19:0]          mul_p;
  logic [13:0]          rem_t;
  logic [13:0]          den14;
  logic [13:0]          two_rem;
  logic                 round_up;
  logic signed [CW-1:0] q_ext;

  // shared unit and memory signals
  absr_pkg::iter_ctl_t  iter_ctl;
  absr_pkg::iter_sts_t  iter_sts;
  logic [19:0]          iter_arg;
  logic [12:0]          iter_res;
  logic [12:0]          iter_rmd;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [31:0]          mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [31:0]          mem_rdata;
  logic [31:0]          blend_px;

  // effective frame and operand forms
  always_comb begin
    eff_w  = (fw > absr_pkg::MAX_W_EXT) ? absr_pkg::MAX_W_EXT : fw;
    eff_h  = (fh > absr_pkg::MAX_H_EXT) ? absr_pkg::MAX_H_EXT : fh;
    ews    = $signed({{(CW-9){1'b0}}, eff_w});
    ehs    = $signed({{(CW-9){1'b0}}, eff_h});
    x0s    = absr_pkg::sx13(x0_q);
    y0s    = absr_pkg::sx13(y0_q);
    x1s    = absr_pkg::sx13(x1_q);
    y1s    = absr_pkg::sx13(y1_q);
    // rectangle clip
    xs     = (x0s < 0) ? '0 : x0s;
    ys     = (y0s < 0) ? '0 : y0s;
    xe_raw = x0s + $signed({{(CW-12){1'b0}}, rw_q});
    ye_raw = y0s + $signed({{(CW-12){1'b0}}, rh_q});
    xe     = (xe_raw > ews) ? ews : xe_raw;
    ye     = (ye_raw > ehs) ? ehs : ye_raw;
    // line endpoints ordered by x
    lswap    = (x0s > x1s);
    xa       = lswap ? x1s : x0s;
    ya       = lswap ? y1s : y0s;
    xb       = lswap ? x0s : x1s;
    dy_line  = (lswap ? y0s : y1s) - ya;
    dy_mag   = (dy_line < 0) ? -dy_line : dy_line;
    dy_abs   = dy_mag[12:0];
    den_line = xb - xa;
    // circle column
    dx_neg = -dx;
    dx_abs = dx[10] ? dx_neg[9:0] : dx[9:0];
    dx_ext = $signed({{(CW-11){dx[10]}}, dx});
    h_ext  = $signed({{(CW-10){1'b0}}, h_q});
    r_s    = $signed({1'b0, r_q});
    // line remainder update and rounding
    rem_t    = {1'b0, lrem} + {1'b0, dr};
    den14    = {1'b0, den_q};
    two_rem  = {lrem, 1'b0};
    round_up = lq[CW-1] ? (two_rem > den14) : (two_rem >= den14);
    q_ext    = $signed({{(CW-13){1'b0}}, iter_res});
  end

  // shared multiplier
  always_comb begin
    if (state == S_SQ) begin
      mul_a = dx_abs;
      mul_b = dx_abs;
    end else if (op_q == absr_pkg::OP_CLEAR) begin
      mul_a = {1'b0, eff_w};
      mul_b = {1'b0, eff_h};
    end else begin
      mul_a = r_q;
      mul_b = r_q;
    end
    mul_p = mul_a * mul_b;
  end

  // shift-subtract unit control
  always_comb begin
    iter_ctl.start = (state == S_ROOT) ||
                     ((state == S_SETUP) && (op_q == absr_pkg::OP_LINE) && (x0_q != x1_q));
    iter_ctl.mode  = (state == S_ROOT) ? absr_pkg::ITER_SQRT : absr_pkg::ITER_DIV;
    iter_arg       = (state == S_SETUP) ? {7'b0, dy_abs} : (rr - dd);
  end

  absr_iter u_iter (
    .clk (clk),
    .rst (rst),
    .ctl (iter_ctl),
    .arg (iter_arg),
    .den (den_q),
    .sts (iter_sts),
    .res (iter_res),
    .rmd (iter_rmd)
  );

  // frame store ports
  always_comb begin
    mem_we    = (state == S_BLEND) || (state == S_CLEAR) || (state == S_INIT);
    mem_waddr = ((state == S_CLEAR) || (state == S_INIT)) ? sweep
                                                          : absr_pkg::pix_addr(px, py);
    if (state == S_INIT) begin
      mem_wdata = '0;
    end else if (state == S_CLEAR) begin
      mem_wdata = col_q;
    end else begin
      mem_wdata = blend_px;
    end
    mem_raddr = (state == S_SETUP) ? absr_pkg::pix_addr(x0s, y0s)
                                   : absr_pkg::pix_addr(px, py);
  end

  absr_frame u_frame (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  absr_blend u_blend (
    .src (col_q),
    .dst (mem_rdata),
    .pix (blend_px)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      fw    <= 9'd256;
      fh    <= 9'd256;
      sweep <= '0;
      cnt   <= '0;
      rd    <= '0;
    end else begin
      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        unique case (absr_pkg::reg_idx_t'(cfg_index))
          absr_pkg::REG_FRAME_WIDTH:  fw <= cfg_data;
          absr_pkg::REG_FRAME_HEIGHT: fh <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        // clearing pass after reset
        S_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(absr_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            op_q  <= absr_pkg::op_t'(op);
            col_q <= color;
            x0_q  <= x0;
            y0_q  <= y0;
            x1_q  <= x1;
            y1_q  <= y1;
            rw_q  <= rect_width;
            rh_q  <= rect_height;
            r_q   <= radius;
            cnt   <= '0;
            rd    <= '0;
            state <= S_SETUP;
          end
        end

        // per-command setup
        S_SETUP: begin
          unique case (op_q)
            absr_pkg::OP_POINT: begin
              px    <= x0s;
              py    <= y0s;
              state <= S_PLOT;
            end
            absr_pkg::OP_RECT: begin
              px     <= xs;
              py     <= ys;
              base_x <= xs;
              lim_x  <= xe;
              lim_y  <= ye;
              state  <= ((xs < xe) && (ys < ye)) ? S_PLOT : S_DONE;
            end
            absr_pkg::OP_CIRC, absr_pkg::OP_OUTL: begin
              rr    <= mul_p;
              dx    <= -r_s;
              pass  <= 1'b0;
              state <= S_SQ;
            end
            absr_pkg::OP_LINE: begin
              if (x0_q == x1_q) begin
                vert  <= 1'b1;
                px    <= x0s;
                py    <= (y0s > y1s) ? y1s : y0s;
                lim_y <= (y0s > y1s) ? y0s : y1s;
                state <= S_PLOT;
              end else begin
                vert  <= 1'b0;
                px    <= xa;
                lim_x <= xb;
                lq    <= ya;
                lrem  <= '0;
                den_q <= den_line[12:0];
                dyneg <= (dy_line < 0);
                state <= S_DIV_WAIT;
              end
            end
            absr_pkg::OP_CLEAR: begin
              cnt   <= mul_p[16:0];
              sweep <= '0;
              state <= S_CLEAR;
            end
            absr_pkg::OP_READ: begin
              state <= absr_pkg::in_frame(x0s, y0s, eff_w, eff_h) ? S_READ : S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end

        // square of the column offset
        S_SQ: begin
          dd    <= mul_p;
          state <= S_ROOT;
        end

        S_ROOT: begin
          state <= S_ROOT_WAIT;
        end

        S_ROOT_WAIT: begin
          if (iter_sts.done) begin
            h_q <= iter_res[9:0];
            px  <= x0s + dx_ext;
            if (op_q == absr_pkg::OP_CIRC) begin
              yoff <= -$signed({{(CW-10){1'b0}}, iter_res[9:0]});
              py   <= y0s - $signed({{(CW-10){1'b0}}, iter_res[9:0]});
            end else if (pass) begin
              py   <= y0s - $signed({{(CW-10){1'b0}}, iter_res[9:0]});
            end else begin
              py   <= y0s + $signed({{(CW-10){1'b0}}, iter_res[9:0]});
            end
            state <= S_PLOT;
          end
        end

        // signed floor step of the line slope
        S_DIV_WAIT: begin
          if (iter_sts.done) begin
            if (!dyneg) begin
              dq <= q_ext;
              dr <= iter_rmd;
            end else if (iter_rmd == '0) begin
              dq <= -q_ext;
              dr <= '0;
            end else begin
              dq <= -q_ext - 2'sd1;
              dr <= den_q - iter_rmd;
            end
            state <= S_LROUND;
          end
        end

        // round half away from zero
        S_LROUND: begin
          py    <= lq + $signed({{(CW-1){1'b0}}, round_up});
          state <= S_PLOT;
        end

        S_PLOT: begin
          state <= absr_pkg::in_frame(px, py, eff_w, eff_h) ? S_BLEND : S_STEP;
        end

        // read-modify-write of one pixel
        S_BLEND: begin
          if (cnt != absr_pkg::COUNT_LIMIT) begin
            cnt <= cnt + 17'd1;
          end
          state <= S_STEP;
        end

        // advance to the next pixel of the shape
        S_STEP: begin
          priority if (op_q == absr_pkg::OP_RECT) begin
            if (px + 2'sd1 < lim_x) begin
              px    <= px + 2'sd1;
              state <= S_PLOT;
            end else if (py + 2'sd1 < lim_y) begin
              px    <= base_x;
              py    <= py + 2'sd1;
              state <= S_PLOT;
            end else begin
              state <= S_DONE;
            end
          end else if ((op_q == absr_pkg::OP_CIRC) && (yoff < h_ext)) begin
            yoff  <= yoff + 2'sd1;
            py    <= py + 2'sd1;
            state <= S_PLOT;
          end else if ((op_q == absr_pkg::OP_CIRC) || (op_q == absr_pkg::OP_OUTL)) begin
            if (dx < r_s) begin
              dx    <= dx + 2'sd1;
              state <= S_SQ;
            end else if ((op_q == absr_pkg::OP_OUTL) && !pass) begin
              pass  <= 1'b1;
              dx    <= -r_s;
              state <= S_SQ;
            end else begin
              state <= S_DONE;
            end
          end else if ((op_q == absr_pkg::OP_LINE) && vert) begin
            if (py < lim_y) begin
              py    <= py + 2'sd1;
              state <= S_PLOT;
            end else begin
              state <= S_DONE;
            end
          end else if (op_q == absr_pkg::OP_LINE) begin
            if (px < lim_x) begin
              px <= px + 2'sd1;
              if (rem_t >= den14) begin
                lrem <= 13'(rem_t - den14);
                lq   <= lq + dq + 2'sd1;
              end else begin
                lrem <= rem_t[12:0];
                lq   <= lq + dq;
              end
              state <= S_LROUND;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end

        // raw fill of the whole store
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == AW'(absr_pkg::DEPTH - 1)) begin
            state <= S_DONE;
          end
        end

        S_READ: begin
          rd    <= mem_rdata;
          state <= S_DONE;
        end

        S_DONE: begin
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // result and handshake outputs
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_DONE);
  assign read_pixel   = rd;
  assign pixels_drawn = cnt;
  assign cfg_ready    = 1'b1;

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe longer than one cycle");

  // no frame store write while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst) !busy |-> !mem_we)
    else $error("frame store written while idle");

  // pixel count saturates
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    pixels_drawn <= absr_pkg::COUNT_LIMIT)
    else $error("pixel count beyond limit");

  // shared unit finishes only while the sequencer waits for it
  a_iter_wait: assert property (@(posedge clk) disable iff (rst)
    iter_sts.done |-> ((state == S_ROOT_WAIT) || (state == S_DIV_WAIT)))
    else $error("shared unit result not awaited");

  // a read command draws nothing
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (done && (op_q == absr_pkg::OP_READ)) |-> (pixels_drawn == 17'd0))
    else $error("read command reported drawn pixels");

endmodule

[test/absr_scoreboard.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// absr_scoreboard: result checker of the shape rasterizer
// Mirrors the frame store and frame registers, works out the read value and
// the written pixel count of every accepted command, and compares them with
// the done transfers of the unit in order.
// ----------------------------------------------------------------------------
module absr_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         op,
  input  logic [31:0]        color,
  input  logic signed [12:0] x0,
  input  logic signed [12:0] y0,
  input  logic signed [12:0] x1,
  input  logic signed [12:0] y1,
  input  logic [11:0]        rect_width,
  input  logic [11:0]        rect_height,
  input  logic [9:0]         radius,
  input  logic               done,
  input  logic [31:0]        read_pixel,
  input  logic [16:0]        pixels_drawn,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [31:0] pixel;
    logic [16:0] drawn;
  } cmd_result_t;

  logic [31:0]  shadow_frame [absr_pkg::DEPTH];
  logic [8:0]   width_reg;
  logic [8:0]   height_reg;
  int           act_w;
  int           act_h;
  int unsigned  write_tally;
  cmd_result_t  result_fifo [4];
  logic [1:0]   fifo_head;
  logic [1:0]   fifo_tail;
  int           fifo_level;

  // blend one source pixel over the shadow frame, clipped to the active frame
  function automatic void blend_plot(input logic [31:0] src, input int x, input int y);
    int unsigned idx;
    int unsigned a;
    int unsigned s;
    int unsigned d;
    logic [31:0] dst;
    logic [31:0] res;
    if (x < 0 || x >= act_w || y < 0 || y >= act_h) return;
    idx = y * absr_pkg::MAX_WIDTH + x;
    dst = shadow_frame[idx];
    a = src[31:24];
    res = {src[31:24], 24'h0};
    for (int sh = 0; sh <= 16; sh += 8) begin
      s = (src >> sh) & 32'hFF;
      d = (dst >> sh) & 32'hFF;
      res |= (((a * s + (255 - a) * d) / 255) & 32'hFF) << sh;
    end
    shadow_frame[idx] = res;
    if (write_tally < 65536) write_tally++;
  endfunction

  // floor square root by shift and subtract
  function automatic int unsigned floor_sqrt(input int unsigned v);
    int unsigned res;
    int unsigned bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // division rounded half away from zero, positive divisor
  function automatic int round_away(input longint num, input longint den);
    if (num >= 0) return int'((2 * num + den) / (2 * den));
    return int'(-((-2 * num + den) / (2 * den)));
  endfunction

  function automatic void draw_segment(input logic [31:0] c, input int xa, input int ya,
                                       input int xb, input int yb);
    int t;
    longint den;
    longint dy;
    if (xa == xb) begin
      if (ya > yb) begin
        t = ya; ya = yb; yb = t;
      end
      for (int y = ya; y <= yb; y++) blend_plot(c, xa, y);
      return;
    end
    if (xa > xb) begin
      t = xa; xa = xb; xb = t;
      t = ya; ya = yb; yb = t;
    end
    den = xb - xa;
    dy = yb - ya;
    for (int x = xa; x <= xb; x++)
      blend_plot(c, x, round_away(longint'(ya) * den + longint'(x - xa) * dy, den));
  endfunction

  // expected result of one command, updating the shadow frame
  function automatic cmd_result_t run_command();
    cmd_result_t r;
    int cx;
    int cy;
    int rad;
    int xs;
    int ys;
    int xe;
    int ye;
    int h;
    int unsigned rr;
    cx = x0;
    cy = y0;
    rad = radius;
    rr = rad * rad;
    r.pixel = '0;
    write_tally = 0;
    act_w = (width_reg > absr_pkg::MAX_WIDTH) ? absr_pkg::MAX_WIDTH : width_reg;
    act_h = (height_reg > absr_pkg::MAX_HEIGHT) ? absr_pkg::MAX_HEIGHT : height_reg;
    case (op)
      absr_pkg::OP_POINT: blend_plot(color, cx, cy);
      absr_pkg::OP_RECT: begin
        xs = cx < 0 ? 0 : cx;
        ys = cy < 0 ? 0 : cy;
        xe = (cx + int'(rect_width) > act_w) ? act_w : cx + int'(rect_width);
        ye = (cy + int'(rect_height) > act_h) ? act_h : cy + int'(rect_height);
        for (int y = ys; y < ye; y++)
          for (int x = xs; x < xe; x++) blend_plot(color, x, y);
      end
      absr_pkg::OP_CIRC: begin
        for (int dx = -rad; dx <= rad; dx++) begin
          h = floor_sqrt(rr - dx * dx);
          for (int y = -h; y <= h; y++) blend_plot(color, cx + dx, cy + y);
        end
      end
      absr_pkg::OP_OUTL: begin
        for (int dx = -rad; dx <= rad; dx++)
          blend_plot(color, cx + dx, cy + int'(floor_sqrt(rr - dx * dx)));
        for (int dx = -rad; dx <= rad; dx++)
          blend_plot(color, cx + dx, cy - int'(floor_sqrt(rr - dx * dx)));
      end
      absr_pkg::OP_LINE: draw_segment(color, cx, cy, x1, y1);
      absr_pkg::OP_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = color;
        write_tally = (act_w * act_h > 65536) ? 65536 : act_w * act_h;
      end
      absr_pkg::OP_READ: begin
        if (cx >= 0 && cx < act_w && cy >= 0 && cy < act_h)
          r.pixel = shadow_frame[cy * absr_pkg::MAX_WIDTH + cx];
      end
      default: ;
    endcase
    r.drawn = write_tally[16:0];
    return r;
  endfunction

  // register writes, command transfers and result checks
  always @(posedge clk) begin
    cmd_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      width_reg = 9'd256;
      height_reg = 9'd256;
      fifo_head = '0;
      fifo_tail = '0;
      fifo_level = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        if (fifo_level == 0) begin
          $error("result transfer with no command outstanding");
          errs++;
        end else begin
          want = result_fifo[fifo_head];
          fifo_head = fifo_head + 2'd1;
          fifo_level--;
          if (read_pixel !== want.pixel) begin
            $error("read_pixel expected %h actual %h", want.pixel, read_pixel);
            errs++;
          end
          if (pixels_drawn !== want.drawn) begin
            $error("pixels_drawn expected %0d actual %0d", want.drawn, pixels_drawn);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == absr_pkg::REG_FRAME_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (start && !busy) begin
        result_fifo[fifo_tail] = run_command();
        fifo_tail = fifo_tail + 2'd1;
        fifo_level++;
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= fifo_level;
    end
  end

endmodule

[test/tb_alpha_blend_shape_rasterizer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alpha_blend_shape_rasterizer_unit: testbench of the shape rasterizer
// Sends directed edge commands, then phases of random commands under several
// frame sizes and sender gap rates; a scoreboard checks every result.
// ----------------------------------------------------------------------------
module tb_alpha_blend_shape_rasterizer_unit;

  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         op;
  logic [31:0]        color;
  logic signed [12:0] x0;
  logic signed [12:0] y0;
  logic signed [12:0] x1;
  logic signed [12:0] y1;
  logic [11:0]        rect_width;
  logic [11:0]        rect_height;
  logic [9:0]         radius;
  logic               done;
  logic [31:0]        read_pixel;
  logic [16:0]        pixels_drawn;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [0:0]         cfg_index;
  logic [8:0]         cfg_data;
  int                 fail_count;
  int                 pending;
  int                 gap_pct;
  int                 cmd_count;
  int                 op_hits [8];

  alpha_blend_shape_rasterizer_unit u_top (.*);

  absr_scoreboard u_scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #(64'd400_000_000);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // one command transfer, with an optional gap in front
  task automatic send_cmd(input logic [2:0] c_op, input logic [31:0] c_color,
                          input int c_x0, input int c_y0, input int c_x1, input int c_y1,
                          input int c_w, input int c_h, input int c_r);
    while (pick(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= c_op;
    color <= c_color;
    x0 <= c_x0[12:0];
    y0 <= c_y0[12:0];
    x1 <= c_x1[12:0];
    y1 <= c_y1[12:0];
    rect_width <= c_w[11:0];
    rect_height <= c_h[11:0];
    radius <= c_r[9:0];
    do @(posedge clk); while (busy);
    op_hits[c_op]++;
    cmd_count++;
  endtask

  // wait until every result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input absr_pkg::reg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[8:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h);
    write_reg(absr_pkg::REG_FRAME_WIDTH, w);
    write_reg(absr_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // random command, mostly small shapes near the active frame
  task automatic random_cmd(input int span);
    int sel;
    logic [31:0] c;
    sel = pick(0, 999);
    c = $urandom();
    if (pick(0, 9) == 0) c[31:24] = pick(0, 1) ? 8'hFF : 8'h00;
    if (sel < 3)
      send_cmd(absr_pkg::OP_CLEAR, c, 0, 0, 0, 0, 0, 0, 0);
    else if (sel < 6)
      send_cmd(absr_pkg::OP_LINE, c, pick(-4096, 4095), pick(-4096, 4095),
               pick(-4096, 4095), pick(-4096, 4095), 0, 0, 0);
    else if (sel < 20)
      send_cmd(OP_UNUSED, c, pick(-4096, 4095), pick(-4096, 4095), pick(-4096, 4095),
               pick(-4096, 4095), pick(0, 4095), pick(0, 4095), pick(0, 1023));
    else if (sel < 120)
      send_cmd(pick(0, 1) ? absr_pkg::OP_POINT : absr_pkg::OP_READ, c,
               pick(-4096, 4095), pick(-4096, 4095), pick(-4096, 4095),
               pick(-4096, 4095), pick(0, 4095), pick(0, 4095), pick(0, 1023));
    else if (sel < 270)
      send_cmd(absr_pkg::OP_POINT, c, pick(-2, span), pick(-2, span), 0, 0, 0, 0, 0);
    else if (sel < 450)
      send_cmd(absr_pkg::OP_READ, c, pick(-2, span), pick(-2, span), 0, 0, 0, 0, 0);
    else if (sel < 600)
      send_cmd(absr_pkg::OP_RECT, c, pick(-20, span), pick(-20, span), 0, 0,
               pick(0, 9) == 0 ? pick(0, 4095) : pick(0, 24),
               pick(0, 9) == 0 ? pick(0, 4095) : pick(0, 24), 0);
    else if (sel < 720)
      send_cmd(absr_pkg::OP_CIRC, c, pick(-10, span + 10), pick(-10, span + 10),
               0, 0, 0, 0, pick(0, 12));
    else if (sel < 830)
      send_cmd(absr_pkg::OP_OUTL, c, pick(-10, span + 10), pick(-10, span + 10),
               0, 0, 0, 0, pick(0, 19) == 0 ? pick(0, 200) : pick(0, 20));
    else
      send_cmd(absr_pkg::OP_LINE, c, pick(-30, span + 30), pick(-30, span + 30),
               pick(-30, span + 30), pick(-30, span + 30), 0, 0, 0);
  endtask

  initial begin
    int frame_w [8] = '{16, 1, 40, 64, 0, 511, 33, 256};
    int frame_h [8] = '{16, 48, 1, 64, 20, 511, 17, 24};
    int gaps [4] = '{0, 69, 11, 69};
    int span;
    rst = 1'b1;
    start = 1'b0;
    op = '0;
    color = '0;
    x0 = '0;
    y0 = '0;
    x1 = '0;
    y1 = '0;
    rect_width = '0;
    rect_height = '0;
    radius = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 0;
    cmd_count = 0;
    foreach (op_hits[i]) op_hits[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, every command, clipping and double blend
    send_cmd(absr_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_POINT, 32'hFF12_3456, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_POINT, 32'h80FF_FFFF, 255, 255, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_POINT, 32'hFFFF_FFFF, -4096, -4096, 4095, 4095, 4095, 4095, 1023);
    send_cmd(absr_pkg::OP_POINT, 32'hFFFF_FFFF, 4095, 4095, -4096, -4096, 0, 0, 0);
    send_cmd(absr_pkg::OP_READ, 0, 255, 255, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_READ, 0, 256, 0, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_RECT, 32'h40AB_CDEF, 10, 10, 0, 0, 0, 5, 0);
    send_cmd(absr_pkg::OP_RECT, 32'h7F00_FF00, -5, -5, 0, 0, 20, 10, 0);
    send_cmd(absr_pkg::OP_RECT, 32'h0112_3456, -4096, -4096, 0, 0, 4095, 4095, 0);
    send_cmd(absr_pkg::OP_CIRC, 32'hC0FF_0000, 100, 100, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_CIRC, 32'hC000_00FF, 2, 253, 0, 0, 0, 0, 6);
    send_cmd(absr_pkg::OP_OUTL, 32'h8080_8080, 50, 50, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_OUTL, 32'h8080_8080, 50, 50, 0, 0, 0, 0, 3);
    send_cmd(absr_pkg::OP_OUTL, 32'hFF00_FF00, 128, 128, 0, 0, 0, 0, 1023);
    send_cmd(absr_pkg::OP_LINE, 32'hFF11_2233, 7, 200, 7, 3, 0, 0, 0);
    send_cmd(absr_pkg::OP_LINE, 32'hA0FF_00FF, 200, 10, 20, 33, 0, 0, 0);
    send_cmd(absr_pkg::OP_LINE, 32'hA0FF_00FF, 0, 0, 9, -5, 0, 0, 0);
    send_cmd(absr_pkg::OP_LINE, 32'h5500_FFFF, -4096, 4095, 4095, -4096, 0, 0, 0);
    send_cmd(absr_pkg::OP_READ, 0, 50, 53, 0, 0, 0, 0, 0);
    send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 5, 5, 6, 6, 7, 7, 8);
    send_cmd(absr_pkg::OP_CLEAR, 32'h1234_5678, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_READ, 0, 255, 0, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_POINT, 32'h00FF_FFFF, 255, 0, 0, 0, 0, 0, 0);
    send_cmd(absr_pkg::OP_READ, 0, 255, 0, 0, 0, 0, 0, 0);
    drain();

    // random phases over frame sizes and gap rates
    for (int ph = 0; ph < 8; ph++) begin
      set_frame(frame_w[ph], frame_h[ph]);
      gap_pct = gaps[ph % 4];
      span = (frame_w[ph] > frame_h[ph]) ? frame_w[ph] : frame_h[ph];
      if (span > 64) span = 64;
      for (int n = 0; n < 100; n++) begin
        random_cmd(span);
        if (pick(0, 49) == 0) begin
          // no gaps for the rest of the phase
          gap_pct = 0;
        end
      end
      drain();
    end

    $display("covered %0d commands: point %0d rect %0d circle %0d outline %0d line %0d",
             cmd_count, op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4]);
    $display("clear %0d read %0d unused %0d over 9 frame settings",
             op_hits[5], op_hits[6], op_hits[7]);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/absr_pkg.sv
design/absr_iter.sv
design/absr_frame.sv
design/absr_blend.sv
design/alpha_blend_shape_rasterizer_unit.sv
test/absr_scoreboard.sv
test/tb_alpha_blend_shape_rasterizer_unit.sv
